// ===== rtl/cdt_pkg.sv =====
// Shared types, codes and lookup functions for the countdown timer controller.
// Used by cdt_core, countdown_timer_controller and cdt_checker; no dependencies.
`timescale 1ns / 1ps

package cdt_pkg;

    // Start-up animation length in frames and the highest settable minute count.
    localparam int ANIMATION_FRAMES = 18;
    localparam int MAX_MINUTES      = 99;
    localparam int ROM_FRAMES       = 18;

    // Item kinds on the input channel.
    localparam logic [1:0] FUNC_BUTTON = 2'd0;
    localparam logic [1:0] FUNC_COUNT  = 2'd1;
    localparam logic [1:0] FUNC_ANIM   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_INITIAL_MINUTES   = 2'd0;
    localparam logic [1:0] CFG_TICKS_PER_MINUTE  = 2'd1;
    localparam logic [1:0] CFG_SHORT_PRESS_TICKS = 2'd2;

    // Mode codes as they appear on the result item.
    localparam logic [2:0] MODE_CODE_START = 3'd0;
    localparam logic [2:0] MODE_CODE_IDLE  = 3'd1;
    localparam logic [2:0] MODE_CODE_SET   = 3'd2;
    localparam logic [2:0] MODE_CODE_RUN   = 3'd3;
    localparam logic [2:0] MODE_CODE_PAUSE = 3'd4;

    // Letters P and A shown while paused.
    localparam logic [6:0] SEG_LETTER_P = 7'h7C;
    localparam logic [6:0] SEG_LETTER_A = 7'h7D;

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_IDLE  = 5'b00010,
        MODE_SET   = 5'b00100,
        MODE_RUN   = 5'b01000,
        MODE_PAUSE = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [1:0] func;
        logic       button_level;
    } t_in_item;

    typedef struct packed {
        logic [6:0] left_segments;
        logic [6:0] right_segments;
        logic       relay_closed;
        logic [2:0] mode;
        logic       save_strobe;
        logic [6:0] save_value;
    } t_out_item;

    typedef struct packed {
        logic [15:0] ticks_per_minute;
        logic [7:0]  short_press_ticks;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic [6:0] value;
    } t_preset_load;

    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] c;
        unique case (m)
            MODE_START: c = MODE_CODE_START;
            MODE_IDLE:  c = MODE_CODE_IDLE;
            MODE_SET:   c = MODE_CODE_SET;
            MODE_RUN:   c = MODE_CODE_RUN;
            MODE_PAUSE: c = MODE_CODE_PAUSE;
            default:    c = MODE_CODE_START;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] digit_seg(input logic [3:0] d);
        logic [6:0] s;
        unique case (d)
            4'd0:    s = 7'h6F;
            4'd1:    s = 7'h09;
            4'd2:    s = 7'h5E;
            4'd3:    s = 7'h5B;
            4'd4:    s = 7'h39;
            4'd5:    s = 7'h73;
            4'd6:    s = 7'h77;
            4'd7:    s = 7'h49;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    function automatic logic [6:0] frame_seg(input logic [7:0] idx);
        logic [6:0] s;
        unique case (idx)
            8'd0:    s = 7'h40;
            8'd1:    s = 7'h28;
            8'd2:    s = 7'h10;
            8'd3:    s = 7'h05;
            8'd4:    s = 7'h02;
            8'd5:    s = 7'h05;
            8'd6:    s = 7'h10;
            8'd7:    s = 7'h28;
            8'd8:    s = 7'h40;
            8'd9:    s = 7'h68;
            8'd10:   s = 7'h78;
            8'd11:   s = 7'h7D;
            8'd12:   s = 7'h7F;
            8'd13:   s = 7'h00;
            8'd14:   s = 7'h7F;
            8'd15:   s = 7'h7F;
            8'd16:   s = 7'h7F;
            8'd17:   s = 7'h00;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

    // Division by five through a reciprocal multiply; exact for eight-bit values.
    function automatic logic [5:0] div5(input logic [7:0] a);
        logic [15:0] p;
        p = 16'(a) * 16'd205;
        return p[15:10];
    endfunction

    function automatic logic mod5_zero(input logic [7:0] a);
        logic [7:0] r;
        r = a - 8'(div5(a) * 8'd5);
        return (r == 8'd0);
    endfunction

    function automatic logic mod15_zero(input logic [7:0] a);
        logic [15:0] p;
        logic [7:0]  r;
        p = 16'(a) * 16'd137;
        r = a - 8'(p[15:11] * 8'd15);
        return (r == 8'd0);
    endfunction

    // Two-digit pattern of a minute count, taken modulo 100.
    function automatic logic [13:0] number_segs(input logic [6:0] v);
        logic [6:0]  w;
        logic [14:0] p;
        logic [3:0]  tens;
        logic [3:0]  ones;
        w    = (v >= 7'd100) ? v - 7'd100 : v;
        p    = 15'(w) * 15'd205;
        tens = p[14:11];
        ones = 4'(w - 7'(tens * 7'd10));
        return {digit_seg(tens), digit_seg(ones)};
    endfunction

endpackage

// ===== rtl/cdt_core.sv =====
// Timer state registers with the event and display logic for one item.
// Depends on cdt_pkg; the result item is registered by the top level.
`timescale 1ns / 1ps

module cdt_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  cdt_pkg::t_in_item    i_item,
    input  cdt_pkg::t_cfg        i_cfg,
    input  cdt_pkg::t_preset_load i_preset_ld,
    output cdt_pkg::t_out_item   o_result
);
    import cdt_pkg::*;

    t_mode       r_mode,      n_mode;
    logic [7:0]  r_anim,      n_anim;
    logic        r_held,      n_held;
    logic [6:0]  r_preset,    n_preset;
    logic [6:0]  r_edit,      n_edit;
    logic [6:0]  r_remaining, n_remaining;
    logic [15:0] r_tick,      n_tick;
    logic        r_counting,  n_counting;
    logic        r_relay,     n_relay;
    logic [6:0]  r_left,      n_left;
    logic [6:0]  r_right,     n_right;
    logic        save_strobe;
    logic [6:0]  save_value;

    always_comb begin
        logic [7:0]  frame_idx;
        logic [6:0]  edit_inc;
        logic [13:0] segs;

        n_mode      = r_mode;
        n_anim      = r_anim;
        n_held      = r_held;
        n_preset    = r_preset;
        n_edit      = r_edit;
        n_remaining = r_remaining;
        n_tick      = r_tick;
        n_counting  = r_counting;
        n_relay     = r_relay;
        n_left      = r_left;
        n_right     = r_right;
        save_strobe = 1'b0;
        save_value  = 7'd0;
        frame_idx   = 8'd0;
        edit_inc    = r_edit + 7'd1;
        segs        = 14'd0;

        unique case (i_item.func)
            FUNC_BUTTON: begin
                if (!r_held) begin
                    if (!i_item.button_level) begin
                        n_held = 1'b1;
                        n_anim = 8'd0;
                    end
                end else if (i_item.button_level) begin
                    n_held = 1'b0;
                    if (r_anim < i_cfg.short_press_ticks) begin
                        unique case (r_mode)
                            MODE_IDLE: begin
                                n_mode      = MODE_RUN;
                                n_remaining = r_preset;
                                n_counting  = 1'b1;
                                n_relay     = 1'b1;
                            end
                            MODE_SET: begin
                                n_edit = (edit_inc > 7'(MAX_MINUTES)) ? 7'd0 : edit_inc;
                                n_anim = 8'd0;
                            end
                            MODE_RUN: begin
                                n_mode     = MODE_PAUSE;
                                n_counting = 1'b0;
                                n_relay    = 1'b0;
                            end
                            MODE_PAUSE: begin
                                n_mode     = MODE_RUN;
                                n_counting = 1'b1;
                                n_relay    = 1'b1;
                            end
                            default: ;
                        endcase
                    end else begin
                        unique case (r_mode)
                            MODE_IDLE: begin
                                n_mode = MODE_SET;
                                n_anim = 8'd0;
                                n_edit = r_preset;
                            end
                            MODE_SET: begin
                                n_preset    = r_edit;
                                save_strobe = 1'b1;
                                save_value  = r_edit;
                                n_mode      = MODE_IDLE;
                            end
                            MODE_RUN, MODE_PAUSE: begin
                                n_mode     = MODE_IDLE;
                                n_counting = 1'b0;
                                n_relay    = 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            FUNC_COUNT: begin
                if (r_counting) begin
                    n_tick = r_tick + 16'd1;
                    if (n_tick >= i_cfg.ticks_per_minute) begin
                        if (r_remaining != 7'd0) begin
                            n_remaining = r_remaining - 7'd1;
                        end
                        n_tick = 16'd0;
                    end
                    if (n_remaining == 7'd0) begin
                        n_counting = 1'b0;
                    end
                end
            end
            FUNC_ANIM: begin
                n_anim = r_anim + 8'd1;
                if (r_mode == MODE_START && mod5_zero(n_anim)) begin
                    // A quotient of zero wraps to the top index and ends the animation.
                    frame_idx = 8'(div5(n_anim)) - 8'd1;
                    if (frame_idx < 8'(ANIMATION_FRAMES)) begin
                        n_left  = frame_seg(frame_idx);
                        n_right = frame_seg(frame_idx);
                    end else begin
                        n_mode = MODE_IDLE;
                    end
                end
            end
            default: ;
        endcase

        // Display update on the state the event has left.
        unique case (n_mode)
            MODE_IDLE: begin
                segs    = number_segs(n_preset);
                n_left  = segs[13:7];
                n_right = segs[6:0];
            end
            MODE_RUN: begin
                segs    = number_segs(n_remaining);
                n_left  = segs[13:7];
                n_right = segs[6:0];
                if (mod15_zero(n_anim)) begin
                    n_left  = 7'd0;
                    n_right = 7'd0;
                end
                if (n_remaining == 7'd0) begin
                    n_mode     = MODE_IDLE;
                    n_relay    = 1'b0;
                    n_counting = 1'b0;
                end
            end
            MODE_PAUSE: begin
                n_left  = SEG_LETTER_P;
                n_right = SEG_LETTER_A;
            end
            MODE_SET: begin
                segs    = number_segs(n_edit);
                n_left  = segs[13:7];
                n_right = segs[6:0];
                if (!n_anim[0]) begin
                    n_left  = 7'd0;
                    n_right = 7'd0;
                end
                if (n_anim == 8'hFF) begin
                    n_mode = MODE_IDLE;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_START;
            r_anim      <= 8'd0;
            r_held      <= 1'b0;
            r_preset    <= 7'd0;
            r_edit      <= 7'd0;
            r_remaining <= 7'd0;
            r_tick      <= 16'd0;
            r_counting  <= 1'b0;
            r_relay     <= 1'b0;
            r_left      <= 7'd0;
            r_right     <= 7'd0;
        end else if (i_preset_ld.load) begin
            r_preset <= i_preset_ld.value;
        end else if (i_accept) begin
            r_mode      <= n_mode;
            r_anim      <= n_anim;
            r_held      <= n_held;
            r_preset    <= n_preset;
            r_edit      <= n_edit;
            r_remaining <= n_remaining;
            r_tick      <= n_tick;
            r_counting  <= n_counting;
            r_relay     <= n_relay;
            r_left      <= n_left;
            r_right     <= n_right;
        end
    end

    assign o_result.left_segments  = n_left;
    assign o_result.right_segments = n_right;
    assign o_result.relay_closed   = n_relay;
    assign o_result.mode           = mode_code(n_mode);
    assign o_result.save_strobe    = save_strobe;
    assign o_result.save_value     = save_value;

endmodule

// ===== rtl/countdown_timer_controller.sv =====
// Top level of the countdown timer controller: configuration registers,
// input handshake and result register. Depends on cdt_pkg and cdt_core.
`timescale 1ns / 1ps

// One-button minute countdown timer with relay and two seven-segment digits.
// Input channel (i_in_valid, i_in_data, o_in_stall): each item is a button
// sample, a count tick or an animation tick, taken at an edge where valid is
// high and stall is low. Every item yields exactly one result item on the
// output channel (o_out_valid, o_out_data, i_out_stall).
// The result of an accepted item is registered and shown from the cycle after
// it is taken. One item is accepted every cycle while o_in_stall is low; the
// timer state and result register update in the same cycle from one logic pass.
// When the receiver stalls, the result register holds its item and o_in_stall
// rises, so no further item is taken until the result has gone.
// Configuration writes (i_cfg_valid, i_cfg_index, i_cfg_data) are always
// ready and take effect at once; writing the initial minutes loads the preset
// from data bits 6:0, saturated to 99. They are to be issued only while no item is in flight.
// Reset is synchronous and active low: the start-up animation begins, the
// relay is open, the result register is empty and the registers return to
// 0 minutes, 1200 ticks per minute and a short press of under 8 ticks.
module countdown_timer_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  cdt_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output cdt_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall,
    input  logic                i_cfg_valid,
    input  logic [1:0]          i_cfg_index,
    input  logic [15:0]         i_cfg_data,
    output logic                o_cfg_ready
);
    import cdt_pkg::*;

    logic         r_out_valid;
    t_out_item    r_out_data;
    t_cfg         r_cfg;
    t_preset_load preset_ld;
    t_out_item    result;
    logic         in_accept;
    logic         cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_accept   = i_in_valid && !o_in_stall;

    assign preset_ld.load  = cfg_write && (i_cfg_index == CFG_INITIAL_MINUTES);
    assign preset_ld.value = (i_cfg_data[6:0] > 7'(MAX_MINUTES)) ? 7'(MAX_MINUTES)
                                                                 : i_cfg_data[6:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ticks_per_minute  <= 16'd1200;
            r_cfg.short_press_ticks <= 8'd8;
        end else if (cfg_write) begin
            if (i_cfg_index == CFG_TICKS_PER_MINUTE) begin
                r_cfg.ticks_per_minute <= i_cfg_data;
            end
            if (i_cfg_index == CFG_SHORT_PRESS_TICKS) begin
                r_cfg.short_press_ticks <= i_cfg_data[7:0];
            end
        end
    end

    cdt_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_cfg       (r_cfg),
        .i_preset_ld (preset_ld),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/cdt_checker.sv =====
// Port-level checks for the countdown timer controller, bound to the top level.
// Depends on cdt_pkg for the item types and mode codes.
`timescale 1ns / 1ps

module cdt_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input cdt_pkg::t_in_item  i_in_data,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input cdt_pkg::t_out_item o_out_data,
    input logic               i_out_stall
);
    import cdt_pkg::*;

    // A stalled result item stays and does not change.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed while stalled");

    // Every accepted item gives a result on the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_out_valid)
        else $error("accepted item produced no result");

    // The relay is closed only while the countdown runs.
    a_relay_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.relay_closed |-> o_out_data.mode == MODE_CODE_RUN)
        else $error("relay closed outside running mode");

    // A save leaves the block idle with a preset in range.
    a_save_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.save_strobe |->
            o_out_data.mode == MODE_CODE_IDLE && o_out_data.save_value <= 7'(MAX_MINUTES))
        else $error("save strobe outside idle or with preset out of range");

    // Without a save the stored value reads as zero.
    a_save_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.save_strobe |-> o_out_data.save_value == 7'd0)
        else $error("save value set without a save strobe");

endmodule

bind countdown_timer_controller cdt_checker u_cdt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_data   (i_in_data),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data),
    .i_out_stall (i_out_stall)
);
